// ===== design/point_morton_key_assert.svh =====
// ----------------------------------------------------------------------------
// point_morton_key_assert.svh
// Assertion macros used by the point_morton_key top module.
// ----------------------------------------------------------------------------
`ifndef POINT_MORTON_KEY_ASSERT_SVH
`define POINT_MORTON_KEY_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define PMK_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmk assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define PMK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmk assertion failed");

`endif

// ===== design/pmk_pkg.sv =====
// ----------------------------------------------------------------------------
// pmk_pkg
// Types and constants of the point Morton key block.
// ----------------------------------------------------------------------------
package pmk_pkg;

   localparam int AXIS_BITS  = 21;
   localparam int INDEX_BITS = 20;
   localparam int AXES       = 3;
   localparam int COORD_BITS = 32;
   localparam int SCALE_BITS = 32;
   localparam int PROD_BITS  = COORD_BITS + SCALE_BITS;
   localparam int QUANT_BITS = PROD_BITS - 32;
   localparam int CODE_BITS  = AXES * AXIS_BITS;
   localparam int CSR_BITS   = 32;

   // Largest quantized axis value, at the width of the truncated product.
   localparam logic [QUANT_BITS-1:0] AXIS_MAX =
      QUANT_BITS'((64'd1 << AXIS_BITS) - 64'd1);

   typedef enum logic [2:0] {
      CSR_MIN_X   = 3'd0,
      CSR_MIN_Y   = 3'd1,
      CSR_MIN_Z   = 3'd2,
      CSR_SCALE_X = 3'd3,
      CSR_SCALE_Y = 3'd4,
      CSR_SCALE_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
      logic signed [COORD_BITS-1:0] coord_z;
      logic        [INDEX_BITS-1:0] point_index;
   } req_data_type;

   typedef struct packed {
      logic [CODE_BITS-1:0]  morton_code;
      logic [INDEX_BITS-1:0] index_out;
   } rsp_data_type;

   // Control that travels with an item down the pipeline.
   typedef struct packed {
      logic                  valid;
      logic [INDEX_BITS-1:0] index;
   } pipe_ctrl_type;

endpackage

// ===== design/point_morton_key.sv =====
// ----------------------------------------------------------------------------
// point_morton_key
// 3D Morton key of one signed Q16.16 point, one point per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Load min_x/y/z and scale_x/y/z through the csr_ write port (csr_we,
//   csr_index, csr_wdata) while no point is in flight. A write takes effect
//   at the clock edge where csr_we is high; there is no read-back.
//   A point transfers at a rising edge where start is high and busy is low.
//   busy is high only during reset, so a new point may follow every cycle.
//   Three axis lanes work side by side: each offsets its coordinate by the
//   box minimum (stage 1) and multiplies by the scale (stage 2); the merge
//   stage saturates the three values and interleaves them (stage 3).
//   The result is on rsp_data with rsp_valid high for exactly one cycle.
//   Throughput is one point per cycle; latency is set by the offset,
//   multiply and merge registers.
//   The receiver cannot stall: every result is taken in its one cycle.
//   Reset (synchronous, active high) clears the configuration registers to
//   zero and empties the pipeline; results in flight are dropped.
// ----------------------------------------------------------------------------
`include "point_morton_key_assert.svh"

module point_morton_key (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  pmk_pkg::req_data_type             req_data,
   output logic                              rsp_valid,
   output pmk_pkg::rsp_data_type             rsp_data,
   input  logic                              csr_we,
   input  pmk_pkg::csr_index_type            csr_index,
   input  logic [pmk_pkg::CSR_BITS-1:0]      csr_wdata
);
   import pmk_pkg::*;

   logic signed [COORD_BITS-1:0] min_ff   [AXES];
   logic        [SCALE_BITS-1:0] scale_ff [AXES];
   logic signed [COORD_BITS-1:0] coord    [AXES];
   logic        [QUANT_BITS-1:0] quant    [AXES];
   logic                         req_accept;
   pipe_ctrl_type                ctrl1_ff;
   pipe_ctrl_type                ctrl2_ff;

   assign busy       = reset;
   assign req_accept = start && !busy;

   // Write configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            min_ff[a]   <= '0;
            scale_ff[a] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_X:   min_ff[0]   <= csr_wdata[COORD_BITS-1:0];
            CSR_MIN_Y:   min_ff[1]   <= csr_wdata[COORD_BITS-1:0];
            CSR_MIN_Z:   min_ff[2]   <= csr_wdata[COORD_BITS-1:0];
            CSR_SCALE_X: scale_ff[0] <= csr_wdata[SCALE_BITS-1:0];
            CSR_SCALE_Y: scale_ff[1] <= csr_wdata[SCALE_BITS-1:0];
            CSR_SCALE_Z: scale_ff[2] <= csr_wdata[SCALE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign coord[0] = req_data.coord_x;
   assign coord[1] = req_data.coord_y;
   assign coord[2] = req_data.coord_z;

   // One lane per axis.
   for (genvar a = 0; a < AXES; a++) begin : g_lane
      pmk_lane u_lane (
         .clock   (clock),
         .coord   (coord[a]),
         .box_min (min_ff[a]),
         .scale   (scale_ff[a]),
         .quant   (quant[a])
      );
   end

   // Advance the transfer strobe and index alongside the lanes.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff.valid <= 1'b0;
         ctrl2_ff.valid <= 1'b0;
      end else begin
         ctrl1_ff.valid <= req_accept;
         ctrl2_ff.valid <= ctrl1_ff.valid;
      end
      ctrl1_ff.index <= req_data.point_index;
      ctrl2_ff.index <= ctrl1_ff.index;
   end

   pmk_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .quant     (quant),
      .ctrl      (ctrl2_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Every transfer yields a result with its index, and no other.
   `PMK_ASSERT_SAME(a_rsp_follows_req, clock, reset, req_accept, ##3 rsp_valid)
   `PMK_ASSERT_SAME(a_rsp_has_req, clock, reset, rsp_valid, $past(req_accept, 3))
   `PMK_ASSERT_SAME(a_index_kept, clock, reset, rsp_valid,
      rsp_data.index_out == $past(req_data.point_index, 3))
   `PMK_ASSERT_NEXT(a_pipe_order, clock, reset, ctrl1_ff.valid, ctrl2_ff.valid)

endmodule

// ===== design/pmk_lane.sv =====
// ----------------------------------------------------------------------------
// pmk_lane
// One axis lane: offset by the box minimum, then scale into Q32.32.
// ----------------------------------------------------------------------------
module pmk_lane (
   input  logic                                 clock,
   input  logic signed [pmk_pkg::COORD_BITS-1:0] coord,
   input  logic signed [pmk_pkg::COORD_BITS-1:0] box_min,
   input  logic        [pmk_pkg::SCALE_BITS-1:0] scale,
   output logic        [pmk_pkg::QUANT_BITS-1:0] quant
);
   import pmk_pkg::*;

   logic signed [COORD_BITS:0]   diff;
   logic        [COORD_BITS-1:0] dist_in;
   logic        [COORD_BITS-1:0] dist_ff;
   logic        [PROD_BITS-1:0]  prod_in;
   logic        [PROD_BITS-1:0]  prod_ff;

   // Offset exactly in one extra bit; clamp points at or below the minimum.
   // A positive offset always fits the unsigned coordinate width.
   always_comb begin
      diff = {coord[COORD_BITS-1], coord} - {box_min[COORD_BITS-1], box_min};
      if (!diff[COORD_BITS] && (diff != '0)) begin
         dist_in = diff[COORD_BITS-1:0];
      end else begin
         dist_in = '0;
      end
   end

   // Scale the offset distance.
   assign prod_in = PROD_BITS'(dist_ff) * PROD_BITS'(scale);

   // Hold each stage.
   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      prod_ff <= prod_in;
   end

   // Drop the fraction: truncation toward zero.
   assign quant = prod_ff[PROD_BITS-1:PROD_BITS-QUANT_BITS];

endmodule

// ===== design/pmk_merge.sv =====
// ----------------------------------------------------------------------------
// pmk_merge
// Saturates the lane results and interleaves them into the Morton code.
// ----------------------------------------------------------------------------
module pmk_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [pmk_pkg::QUANT_BITS-1:0]       quant [pmk_pkg::AXES],
   input  pmk_pkg::pipe_ctrl_type               ctrl,
   output logic                                 rsp_valid,
   output pmk_pkg::rsp_data_type                rsp_data
);
   import pmk_pkg::*;

   logic [AXIS_BITS-1:0] sat [AXES];
   logic [CODE_BITS-1:0] code_in;
   rsp_data_type         data_ff;
   logic                 valid_ff;

   // Saturate every axis value to the code range.
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         if (quant[a] > AXIS_MAX) begin
            sat[a] = AXIS_MAX[AXIS_BITS-1:0];
         end else begin
            sat[a] = quant[a][AXIS_BITS-1:0];
         end
      end
   end

   // Interleave: x in bit 0, y in bit 1, z in bit 2 of each triple.
   always_comb begin
      for (int b = 0; b < AXIS_BITS; b++) begin
         for (int a = 0; a < AXES; a++) begin
            code_in[b*AXES + a] = sat[a][b];
         end
      end
   end

   // Register the result and its strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl.valid;
      end
      data_ff.morton_code <= code_in;
      data_ff.index_out   <= ctrl.index;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== tb/tb_point_morton_key.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_morton_key
// Self-checking testbench for the 3D point Morton key block.
// ----------------------------------------------------------------------------
// A queue of points feeds a clocked driver that presents them with random
// gaps. A clocked monitor mirrors every register write, predicts the Morton
// key of each transferred point, and compares every result strobe with the
// oldest predicted key. The run starts with directed points (zero scale,
// box edges, saturation boundary, index extremes), then sweeps several
// random box settings with mostly in-box points and some off-box noise.
// ----------------------------------------------------------------------------
module tb_point_morton_key;
   import pmk_pkg::*;

   localparam int CLOCK_HALF  = 2;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 140;
   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 8;

   typedef enum int {
      BOX_FIT,
      BOX_EXTREME,
      BOX_RANDOM
   } box_mode_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   req_data_type  req_data = '0;
   logic          rsp_valid;
   rsp_data_type  rsp_data;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_MIN_X;
   logic [CSR_BITS-1:0] csr_wdata = '0;

   // Stimulus side: queued points and the box they are drawn around.
   req_data_type pending_points[$];
   logic [31:0]  box_lo    [AXES];
   logic [31:0]  box_span  [AXES];
   logic [31:0]  box_scale [AXES];
   int           points_queued = 0;

   // Checking side: mirrored registers and keys still to arrive.
   logic [31:0]  model_min   [AXES] = '{default: '0};
   logic [31:0]  model_scale [AXES] = '{default: '0};
   rsp_data_type expected_keys[$];
   int           points_taken = 0;
   int           fail_count   = 0;
   int           stall_cycles = 0;
   logic         req_taken    = 1'b0;

   // Driver pacing.
   int           idle_left   = 0;
   int           steady_left = 0;

   point_morton_key u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // Quantize each axis against the mirrored box and interleave the bits.
   function automatic rsp_data_type morton_key_of(req_data_type pt);
      logic [31:0]          crd [AXES];
      logic signed [32:0]   delta;
      logic [63:0]          prod;
      logic [AXIS_BITS-1:0] q;
      rsp_data_type         key;
      crd[0] = pt.coord_x;
      crd[1] = pt.coord_y;
      crd[2] = pt.coord_z;
      key.morton_code = '0;
      for (int a = 0; a < AXES; a++) begin
         delta = {crd[a][31], crd[a]} - {model_min[a][31], model_min[a]};
         if (delta <= 0) begin
            q = '0;
         end else begin
            prod = 64'(delta[31:0]) * 64'(model_scale[a]);
            if (prod[63:32] > 32'((64'd1 << AXIS_BITS) - 64'd1))
               q = '1;
            else
               q = prod[32 +: AXIS_BITS];
         end
         for (int b = 0; b < AXIS_BITS; b++)
            key.morton_code[AXES * b + a] = q[b];
      end
      key.index_out = pt.point_index;
      return key;
   endfunction

   function automatic req_data_type point_at(logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z,
                                             logic [INDEX_BITS-1:0] idx);
      req_data_type pt;
      pt.coord_x     = x;
      pt.coord_y     = y;
      pt.coord_z     = z;
      pt.point_index = idx;
      return pt;
   endfunction

   // Draw one coordinate: mostly inside the box, some at its edges, some off.
   function automatic logic [31:0] pick_coord(int a);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return box_lo[a] + $urandom_range(0, box_span[a]);
      else if (roll < 76)
         return box_lo[a] + 32'($urandom_range(0, 6)) - 32'd3;
      else if (roll < 82)
         return box_lo[a] + box_span[a] + 32'($urandom_range(0, 6)) - 32'd3;
      else if (roll < 88)
         return box_lo[a] + box_span[a] + $urandom;
      else
         return $urandom;
   endfunction

   task automatic push_point(req_data_type pt);
      pending_points = {pending_points, pt};
      points_queued++;
   endtask

   // Hold until every queued point is taken and every key has come back.
   task automatic wait_idle();
      while (points_taken != points_queued || expected_keys.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   task automatic write_box();
      write_reg(CSR_MIN_X, box_lo[0]);
      write_reg(CSR_MIN_Y, box_lo[1]);
      write_reg(CSR_MIN_Z, box_lo[2]);
      write_reg(CSR_SCALE_X, box_scale[0]);
      write_reg(CSR_SCALE_Y, box_scale[1]);
      write_reg(CSR_SCALE_Z, box_scale[2]);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Pick a box per axis in the given style.
   task automatic set_box(box_mode_type mode);
      for (int a = 0; a < AXES; a++) begin
         case (mode)
            BOX_FIT: begin
               // scale maps the span onto the full axis range
               box_span[a]  = $urandom_range(32'h8000_0000, 32'h0040_0000);
               box_lo[a]    = 32'h8000_0000 + $urandom_range(0, ~box_span[a]);
               box_scale[a] = 32'(((64'd1 << 53) - 64'd1) / 64'(box_span[a]));
            end
            BOX_EXTREME: begin
               case ($urandom_range(0, 2))
                  0: box_lo[a] = 32'h8000_0000;
                  1: box_lo[a] = 32'h7fff_ffff;
                  default: box_lo[a] = '0;
               endcase
               case ($urandom_range(0, 2))
                  0: box_scale[a] = '0;
                  1: box_scale[a] = 32'hffff_ffff;
                  default: box_scale[a] = 32'd1;
               endcase
               box_span[a] = $urandom;
            end
            default: begin
               box_lo[a]    = $urandom;
               box_span[a]  = $urandom;
               box_scale[a] = $urandom;
            end
         endcase
      end
   endtask

   // Present queued points at the falling edge, with random gaps between them.
   always @(negedge clock) begin
      int roll;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (idle_left > 0) begin
            start <= 1'b0;
            idle_left--;
         end else if (pending_points.size() != 0) begin
            req_data <= pending_points.pop_front();
            start    <= 1'b1;
            // choose the gap after this transfer
            if (steady_left > 0) begin
               steady_left--;
            end else if ($urandom_range(0, 19) == 0) begin
               steady_left = $urandom_range(20, 120);
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 55)
                  idle_left = 0;
               else if (roll < 85)
                  idle_left = $urandom_range(1, 3);
               else if (roll < 97)
                  idle_left = $urandom_range(4, 12);
               else
                  idle_left = $urandom_range(20, 60);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Predict on each transfer, mirror register writes, check every result.
   always @(posedge clock) begin
      rsp_data_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            expected_keys = {expected_keys, morton_key_of(req_data)};
            points_taken++;
            req_taken = 1'b1;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_X:   model_min[0]   = csr_wdata;
               CSR_MIN_Y:   model_min[1]   = csr_wdata;
               CSR_MIN_Z:   model_min[2]   = csr_wdata;
               CSR_SCALE_X: model_scale[0] = csr_wdata;
               CSR_SCALE_Y: model_scale[1] = csr_wdata;
               CSR_SCALE_Z: model_scale[2] = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_keys.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: code %h index %h",
                           rsp_data.morton_code, rsp_data.index_out);
            end else begin
               want = expected_keys.pop_front();
               if (rsp_data.morton_code !== want.morton_code) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("morton_code mismatch: expected %h actual %h",
                              want.morton_code, rsp_data.morton_code);
               end
               if (rsp_data.index_out !== want.index_out) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("index_out mismatch: expected %h actual %h",
                              want.index_out, rsp_data.index_out);
               end
            end
         end
         // watchdog: count cycles without any transfer, result or register write
         if (req_taken || rsp_valid || csr_we)
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("** point_morton_key: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zero scale after reset: every key is zero.
      push_point(point_at(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 20'hfffff));
      push_point(point_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 20'h00000));
      push_point(point_at(32'h1234_5678, 32'hdead_beef, 32'h0001_0000, 20'h5a5a5));
      wait_idle();

      // Directed box: x lowest minimum with full scale, y unit scale,
      // z highest minimum with the smallest scale.
      box_lo    = '{32'h8000_0000, 32'h0000_0000, 32'h7fff_ffff};
      box_scale = '{32'hffff_ffff, 32'h0001_0000, 32'h0000_0001};
      write_box();
      // at the minimum, below it, just above it
      push_point(point_at(32'h8000_0000, 32'h0000_0000, 32'h7fff_ffff, 20'h00001));
      push_point(point_at(32'h8000_0000, 32'hffff_ffff, 32'h8000_0000, 20'h00002));
      push_point(point_at(32'h8000_0001, 32'h0000_0001, 32'h7fff_fffe, 20'h00004));
      // top of the coordinate range: x saturates
      push_point(point_at(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 20'hfffff));
      // around the saturation boundary on x
      push_point(point_at(32'h801f_ffff, 32'h0001_0000, 32'h0000_0000, 20'h80000));
      push_point(point_at(32'h8020_0000, 32'h0002_0000, 32'h0000_0000, 20'h40000));
      push_point(point_at(32'h8020_0001, 32'h7fff_0000, 32'h0000_0000, 20'h0ffff));
      push_point(point_at(32'h8020_0002, 32'h5555_5555, 32'haaaa_aaaa, 20'haaaaa));
      push_point(point_at(32'haaaa_aaaa, 32'h2aaa_aaaa, 32'h5555_5555, 20'h55555));
      push_point(point_at(32'h8015_5555, 32'h000a_aaaa, 32'hffff_ffff, 20'h12345));
      wait_idle();

      // Random sweep over several box settings.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph % 4)
            1: set_box(BOX_RANDOM);
            3: set_box(BOX_EXTREME);
            default: set_box(BOX_FIT);
         endcase
         write_box();
         for (int i = 0; i < PHASE_ITEMS; i++)
            push_point(point_at(pick_coord(0), pick_coord(1), pick_coord(2),
                                INDEX_BITS'($urandom_range(0, 20'hfffff))));
         wait_idle();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("** point_morton_key: PASSED **");
      else
         $display("** point_morton_key: FAILED **");
      $finish;
   end

endmodule
